@@ design/assert_macros.svh @@
// Assertion macros for the checker module of the queue unit.
// The macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define SPMQ_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define SPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/spmq_pkg.sv @@
// Shared types and constants for the strict priority message queue unit.
// No dependencies.
package spmq_pkg;

    localparam int DEF_PRIORITY_LEVELS = 8;
    localparam int DEF_CAPACITY        = 256;
    localparam int DEF_HANDLE_BITS     = 16;

    localparam int PRI_W    = 4;
    localparam int HANDLE_W = 16;
    localparam int TOTAL_W  = 9;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPRI = 2'd3
    } t_status;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef struct packed {
        logic set_head;
        logic set_tail;
        logic set_ne;
        logic clr_ne;
    } t_lvl_ctl;

endpackage

@@ design/spmq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module spmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/spmq_level_ctl.sv @@
// Per-level head and tail pointers, nonempty flags and the top-level search.
// Depends on spmq_pkg.
module spmq_level_ctl #(
    parameter int PRIORITY_LEVELS = 8,
    parameter int CAPACITY        = 256,
    parameter int LW              = $clog2(PRIORITY_LEVELS),
    parameter int AW              = $clog2(CAPACITY)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LW-1:0]     i_lvl,
    input  spmq_pkg::t_lvl_ctl i_ctl,
    input  logic [AW-1:0]     i_head_d,
    input  logic [AW-1:0]     i_tail_d,
    output logic [AW-1:0]     o_head,
    output logic [AW-1:0]     o_tail,
    output logic              o_ne,
    output logic [LW-1:0]     o_top_lvl,
    output logic              o_any
);

    import spmq_pkg::*;

    logic [AW-1:0]              r_head [PRIORITY_LEVELS];
    logic [AW-1:0]              r_tail [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] r_ne;
    logic [LW-1:0]              w_top;

    always_ff @(posedge i_clk) begin
        if (i_ctl.set_head) begin
            r_head[i_lvl] <= i_head_d;
        end
        if (i_ctl.set_tail) begin
            r_tail[i_lvl] <= i_tail_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne <= '0;
        end else begin
            if (i_ctl.set_ne) begin
                r_ne[i_lvl] <= 1'b1;
            end
            if (i_ctl.clr_ne) begin
                r_ne[i_lvl] <= 1'b0;
            end
        end
    end

    always_comb begin
        w_top = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (r_ne[i]) begin
                w_top = LW'(i);
            end
        end
    end

    assign o_head    = r_head[i_lvl];
    assign o_tail    = r_tail[i_lvl];
    assign o_ne      = r_ne[i_lvl];
    assign o_top_lvl = w_top;
    assign o_any     = |r_ne;

endmodule

@@ design/strict_priority_message_queue_unit.sv @@
// Top level of the strict priority message queue unit.
// Depends on spmq_pkg, spmq_ram and spmq_level_ctl.
//
// Requests arrive on the s_axis channel. Each request either enqueues a
// handle at a priority level or dequeues the oldest handle of the highest
// nonempty level. Every request produces exactly one response on the m_axis
// channel carrying a status, the dequeued handle and the number of handles
// held after the request.
// A request is accepted and its memories are read; once the response register
// is free, the result is written back and that register is loaded. A new
// request is taken only after the one in flight has been written back; the
// registered read of the handle, link and free-slot memories sets this pace.
// The response register decouples the channels: a new request is taken while
// a response still waits. If the receiver stalls, the request in flight holds
// until the response register frees, and s_axis_tready stays low meanwhile.
// Reset empties every level and the free-slot list at once, with no clearing
// pass; slots are handed out starting from slot zero.
module strict_priority_message_queue_unit #(
    parameter int PRIORITY_LEVELS = spmq_pkg::DEF_PRIORITY_LEVELS,
    parameter int CAPACITY        = spmq_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS     = spmq_pkg::DEF_HANDLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: priority_req[3:0], message_handle[19:4], zero fill.
    input  logic [spmq_pkg::S_DATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: opcode.
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: handle_out[15:0], queued_total[24:16], zero fill.
    output logic [spmq_pkg::M_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]                    m_axis_tuser
);

    import spmq_pkg::*;

    localparam int LW = $clog2(PRIORITY_LEVELS);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = HANDLE_BITS;

    logic            r_busy;
    t_opcode         r_op;
    logic            r_bad;
    logic [LW-1:0]   r_lvl;
    logic            r_any;
    logic [HW-1:0]   r_h;
    logic [AW-1:0]   r_dslot;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_high;
    logic            r_ovalid;
    t_status         r_status;
    logic [HANDLE_W-1:0] r_hout;
    logic [TOTAL_W-1:0]  r_total;

    logic [CW-1:0]   n_count;
    logic [CW-1:0]   n_high;
    t_status         n_status;
    logic [HANDLE_W-1:0] n_hout;

    logic            w_accept;
    logic            w_done;
    t_opcode         w_op;
    logic [PRI_W-1:0] w_pri;
    logic            w_bad;
    logic [LW-1:0]   w_acc_lvl;
    logic [LW-1:0]   w_lvl;
    logic [63:0]     w_h64;
    logic [63:0]     w_got64;
    logic [31:0]     w_total32;
    logic            w_not_full;
    logic [AW-1:0]   w_eslot;

    t_lvl_ctl        w_ctl;
    logic [AW-1:0]   w_head_d;
    logic [AW-1:0]   w_head;
    logic [AW-1:0]   w_tail;
    logic            w_ne;
    logic [LW-1:0]   w_top_lvl;
    logic            w_any_now;

    logic            w_hs_wr;
    logic            w_lk_wr;
    logic            w_fr_wr;
    logic            w_fr_rd;
    logic            w_dq_rd;
    logic [HW-1:0]   w_hs_rdata;
    logic [AW-1:0]   w_lk_rdata;
    logic [AW-1:0]   w_fr_rdata;

    assign w_op      = t_opcode'(s_axis_tuser);
    assign w_pri     = s_axis_tdata[PRI_W-1:0];
    assign w_bad     = {1'b0, w_pri} >= (PRI_W + 1)'(PRIORITY_LEVELS);
    assign w_acc_lvl = (w_op == OP_ENQ) ? w_pri[LW-1:0] : w_top_lvl;
    assign w_lvl     = r_busy ? r_lvl : w_acc_lvl;
    assign w_h64     = 64'(s_axis_tdata[PRI_W +: HANDLE_W]);

    assign w_accept   = s_axis_tvalid && !r_busy;
    assign w_done     = r_busy && (!r_ovalid || m_axis_tready);
    assign w_not_full = r_count < CW'(CAPACITY);
    assign w_eslot    = (r_count < r_high) ? w_fr_rdata : r_count[AW-1:0];

    assign w_fr_rd = w_accept && (w_op == OP_ENQ) && w_not_full;
    assign w_dq_rd = w_accept && (w_op == OP_DEQ);

    always_comb begin
        n_count  = r_count;
        n_high   = r_high;
        n_status = ST_OK;
        n_hout   = '0;
        w_ctl    = '0;
        w_head_d = w_eslot;
        w_hs_wr  = 1'b0;
        w_lk_wr  = 1'b0;
        w_fr_wr  = 1'b0;
        w_got64  = 64'(w_hs_rdata);
        if (r_op == OP_ENQ) begin
            if (r_bad) begin
                n_status = ST_BADPRI;
            end else if (!w_not_full) begin
                n_status = ST_FULL;
            end else begin
                n_count      = r_count + CW'(1);
                n_high       = (r_count == r_high) ? n_count : r_high;
                w_hs_wr      = w_done;
                w_lk_wr      = w_done && w_ne;
                w_ctl.set_tail = w_done;
                w_ctl.set_head = w_done && !w_ne;
                w_ctl.set_ne   = w_done && !w_ne;
            end
        end else begin
            if (!r_any) begin
                n_status = ST_EMPTY;
            end else begin
                n_count  = r_count - CW'(1);
                n_hout   = w_got64[HANDLE_W-1:0];
                w_fr_wr  = w_done;
                w_head_d = w_lk_rdata;
                w_ctl.clr_ne   = w_done && (w_tail == r_dslot);
                w_ctl.set_head = w_done && (w_tail != r_dslot);
            end
        end
    end

    assign w_total32 = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            r_high   <= '0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
                r_count  <= n_count;
                r_high   <= n_high;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= w_op;
            r_bad   <= w_bad;
            r_lvl   <= w_acc_lvl;
            r_any   <= w_any_now;
            r_h     <= w_h64[HW-1:0];
            r_dslot <= w_head;
        end
        if (w_done) begin
            r_status <= n_status;
            r_hout   <= n_hout;
            r_total  <= w_total32[TOTAL_W-1:0];
        end
    end

    spmq_level_ctl #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .CAPACITY        (CAPACITY),
        .LW              (LW),
        .AW              (AW)
    ) u_level_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lvl     (w_lvl),
        .i_ctl     (w_ctl),
        .i_head_d  (w_head_d),
        .i_tail_d  (w_eslot),
        .o_head    (w_head),
        .o_tail    (w_tail),
        .o_ne      (w_ne),
        .o_top_lvl (w_top_lvl),
        .o_any     (w_any_now)
    );

    spmq_ram #(
        .WIDTH (HW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_handle_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_hs_wr),
        .i_wr_addr (w_eslot),
        .i_wr_data (r_h),
        .i_rd_en   (w_dq_rd),
        .i_rd_addr (w_head),
        .o_rd_data (w_hs_rdata)
    );

    spmq_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_lk_wr),
        .i_wr_addr (w_tail),
        .i_wr_data (w_eslot),
        .i_rd_en   (w_dq_rd),
        .i_rd_addr (w_head),
        .o_rd_data (w_lk_rdata)
    );

    spmq_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_free_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_fr_wr),
        .i_wr_addr (n_count[AW-1:0]),
        .i_wr_data (r_dslot),
        .i_rd_en   (w_fr_rd),
        .i_rd_addr (r_count[AW-1:0]),
        .o_rd_data (w_fr_rdata)
    );

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(M_DATA_W - TOTAL_W - HANDLE_W)'(0), r_total, r_hout};
    assign m_axis_tuser  = r_status;

endmodule

@@ design/spmq_checker.sv @@
// Port-level checker for the strict priority message queue unit, with its bind.
// Depends on spmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spmq_checker #(
    parameter int CAPACITY = spmq_pkg::DEF_CAPACITY
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          i_s_tready,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [spmq_pkg::M_DATA_W-1:0] i_m_tdata,
    input logic [1:0]                    i_m_tuser
);

    import spmq_pkg::*;

    `SPMQ_ASSERT(a_empty_zero, i_m_tvalid && (i_m_tuser == ST_EMPTY),
        i_m_tdata[24:0] == 25'd0, "Empty response must report no handle and no count.")

    `SPMQ_ASSERT(a_full_count, i_m_tvalid && (i_m_tuser == ST_FULL),
        i_m_tdata[24:16] == 9'(CAPACITY), "Full response must report a full store.")

    `SPMQ_ASSERT(a_handle_ok, i_m_tvalid && (i_m_tdata[15:0] != 16'd0),
        i_m_tuser == ST_OK, "A handle may only be returned with an ok status.")

    `SPMQ_ASSERT_NEXT(a_one_in_flight, i_s_tvalid && i_s_tready,
        !i_s_tready, "A second request was taken while one was in flight.")

    `SPMQ_ASSERT_NEXT(a_resp_hold, i_m_tvalid && !i_m_tready,
        i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser),
        "A stalled response changed.")

endmodule

bind strict_priority_message_queue_unit spmq_checker #(
    .CAPACITY (CAPACITY)
) u_spmq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

@@ sim/strict_priority_message_queue_unit_tb.sv @@
// Self-checking testbench for the strict priority message queue unit.
// Depends on spmq_pkg and the strict_priority_message_queue_unit RTL.
// Drives enqueue and dequeue requests with random idling and checks responses.
`timescale 1ns / 1ps

module strict_priority_message_queue_unit_tb;
    import spmq_pkg::*;

    localparam int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS;
    localparam int CAPACITY        = DEF_CAPACITY;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 10;

    typedef struct packed {
        t_status     st;
        logic [15:0] hnd;
        logic [8:0]  tot;
    } t_resp;

    typedef struct packed {
        t_opcode     op;
        logic [3:0]  pri;
        logic [15:0] hnd;
        logic        typed;
        t_resp       want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    logic [15:0] level_fifo [PRIORITY_LEVELS][$];
    t_resp       due_responses [$];
    t_dir_row    dir_tab [22];

    int  held_cnt = 0;
    int  peak_held = 0;
    int  n_sent = 0;
    int  n_deq = 0;
    int  n_full = 0;
    int  n_empty = 0;
    int  n_badpri = 0;
    int  err_cnt = 0;
    int  cycles = 0;
    bit  tx_idle_en = 1'b1;
    bit  rx_idle_en = 1'b1;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;

    strict_priority_message_queue_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time,
                     due_responses.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Strict priority: the highest nonempty level is served, FIFO within a level.
    function automatic t_resp serve_request(t_opcode op, logic [3:0] pri,
                                            logic [15:0] h);
        t_resp r;
        r.st  = ST_OK;
        r.hnd = '0;
        if (op == OP_ENQ) begin
            if (pri >= PRIORITY_LEVELS) begin
                r.st = ST_BADPRI;
                n_badpri++;
            end else if (held_cnt >= CAPACITY) begin
                r.st = ST_FULL;
                n_full++;
            end else begin
                level_fifo[pri].push_back(h);
                held_cnt++;
            end
        end else begin
            r.st = ST_EMPTY;
            for (int lv = PRIORITY_LEVELS - 1; lv >= 0; lv--) begin
                if (r.st == ST_EMPTY && level_fifo[lv].size() != 0) begin
                    r.hnd = level_fifo[lv].pop_front();
                    r.st  = ST_OK;
                    held_cnt--;
                    n_deq++;
                end
            end
            if (r.st == ST_EMPTY) begin
                n_empty++;
            end
        end
        r.tot = 9'(held_cnt);
        if (held_cnt > peak_held) begin
            peak_held = held_cnt;
        end
        return r;
    endfunction

    task automatic send_req(input t_opcode op, input logic [3:0] pri,
                            input logic [15:0] h, input logic typed, input t_resp want);
        t_resp r;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, h, pri};
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        r = serve_request(op, pri, h);
        due_responses.push_back(typed ? want : r);
        n_sent++;
    endtask

    task automatic sender_idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_all_answered();
        sender_idle(1);
        while (due_responses.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic random_request(input int enq_pct);
        t_opcode     op;
        logic [3:0]  pri;
        logic [15:0] h;
        op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        pri = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(8, 15))
                                           : 4'($urandom_range(0, 7));
        h   = 16'($urandom);
        send_req(op, pri, h, 1'b0, '0);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            sender_idle($urandom_range(1, 14));
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_resp got;
        t_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.st  = t_status'(m_axis_tuser);
            got.hnd = m_axis_tdata[15:0];
            got.tot = m_axis_tdata[24:16];
            if (due_responses.size() == 0) begin
                $display("%0t: unexpected response st=%0d hnd=%h tot=%0d", $time,
                         got.st, got.hnd, got.tot);
                err_cnt++;
            end else begin
                want = due_responses.pop_front();
                if (got.st != want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.st, got.st);
                    err_cnt++;
                end
                if (got.hnd != want.hnd) begin
                    $display("%0t: handle expected %h actual %h", $time,
                             want.hnd, got.hnd);
                    err_cnt++;
                end
                if (got.tot != want.tot) begin
                    $display("%0t: total expected %0d actual %0d", $time,
                             want.tot, got.tot);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        int start_cnt;
        int guard;
        dir_tab = '{
            '{OP_DEQ, 4'd0,  16'h0000, 1'b1, '{ST_EMPTY,  16'h0000, 9'd0}},
            '{OP_DEQ, 4'd15, 16'hFFFF, 1'b1, '{ST_EMPTY,  16'h0000, 9'd0}},
            '{OP_ENQ, 4'd8,  16'hAAAA, 1'b1, '{ST_BADPRI, 16'h0000, 9'd0}},
            '{OP_ENQ, 4'd15, 16'hFFFF, 1'b1, '{ST_BADPRI, 16'h0000, 9'd0}},
            '{OP_ENQ, 4'd0,  16'h0000, 1'b1, '{ST_OK,     16'h0000, 9'd1}},
            '{OP_ENQ, 4'd7,  16'hFFFF, 1'b1, '{ST_OK,     16'h0000, 9'd2}},
            '{OP_ENQ, 4'd0,  16'h5555, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_ENQ, 4'd3,  16'h1234, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_ENQ, 4'd7,  16'h8001, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_ENQ, 4'd12, 16'h7777, 1'b1, '{ST_BADPRI, 16'h0000, 9'd5}},
            '{OP_DEQ, 4'd9,  16'hAAAA, 1'b1, '{ST_OK,     16'hFFFF, 9'd4}},
            '{OP_DEQ, 4'd0,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd0,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd0,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd0,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd0,  16'h0000, 1'b1, '{ST_EMPTY,  16'h0000, 9'd0}},
            '{OP_ENQ, 4'd5,  16'h00FF, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd5,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_ENQ, 4'd1,  16'hFF00, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_ENQ, 4'd1,  16'h0F0F, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd2,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}},
            '{OP_DEQ, 4'd1,  16'h0000, 1'b0, '{ST_OK,     16'h0000, 9'd0}}
        };
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_req(dir_tab[i].op, dir_tab[i].pri, dir_tab[i].hnd,
                     dir_tab[i].typed, dir_tab[i].want);
            if ($urandom_range(0, 3) == 0) begin
                sender_idle($urandom_range(1, 14));
            end
        end

        // Balanced mix; partway through the receiver holds off for a long stretch.
        for (int i = 0; i < 300; i++) begin
            if (i == 150) begin
                long_hold_req = 1'b1;
            end
            random_request(55);
        end

        wait_all_answered();

        // Enqueue-heavy traffic until the shared store has overflowed many times.
        guard = 0;
        while (n_full < 20 && guard < 700) begin
            random_request(85);
            guard++;
        end

        // Dequeue-heavy traffic until the queue has run dry repeatedly.
        start_cnt = n_empty;
        guard = 0;
        while (n_empty < start_cnt + 15 && guard < 700) begin
            random_request(15);
            guard++;
        end

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < 200; i++) begin
            random_request(50);
        end

        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_responses.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, due_responses.size());
            err_cnt++;
        end

        $display("Sent %0d requests: %0d handles dequeued, peak occupancy %0d of %0d.",
                 n_sent, n_deq, peak_held, CAPACITY);
        $display("Error responses: %0d full, %0d empty, %0d bad priority; %0d mismatches.",
                 n_full, n_empty, n_badpri, err_cnt);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/spmq_pkg.sv
design/spmq_ram.sv
design/spmq_level_ctl.sv
design/strict_priority_message_queue_unit.sv
design/spmq_checker.sv
sim/strict_priority_message_queue_unit_tb.sv
